// ----- sv/bcp_pkg.sv -----
// shared types, constants and the cordic arc table for the bean curve point block
`default_nettype none
package bcp_pkg;

  localparam int PHASE_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS    = 28;
  localparam int WORD_BITS       = 32;
  localparam int ANGLE_BITS      = 32;
  localparam int FRAC_BITS       = 30;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t CORDIC_GAIN = 32'sd652032874;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef struct packed {
    word_t      x;
    word_t      y;
    word_t      z;
    logic [1:0] quad;
  } cordic_t;

  function automatic word_t arc_at(input int step);
    word_t a;
    case (step)
      0:       a = 32'sd536870912;
      1:       a = 32'sd316933406;
      2:       a = 32'sd167458907;
      3:       a = 32'sd85004756;
      4:       a = 32'sd42667331;
      5:       a = 32'sd21354465;
      6:       a = 32'sd10679838;
      7:       a = 32'sd5340245;
      8:       a = 32'sd2670163;
      9:       a = 32'sd1335087;
      10:      a = 32'sd667544;
      11:      a = 32'sd333772;
      12:      a = 32'sd166886;
      13:      a = 32'sd83443;
      14:      a = 32'sd41722;
      15:      a = 32'sd20861;
      16:      a = 32'sd10430;
      17:      a = 32'sd5215;
      18:      a = 32'sd2608;
      19:      a = 32'sd1304;
      20:      a = 32'sd652;
      21:      a = 32'sd326;
      22:      a = 32'sd163;
      23:      a = 32'sd81;
      24:      a = 32'sd41;
      25:      a = 32'sd20;
      26:      a = 32'sd10;
      27:      a = 32'sd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- sv/bcp_cordic_cell.sv -----
// one registered cordic rotation cell with its own valid and stall handshake
`default_nettype none
module bcp_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire bcp_pkg::cordic_t up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output bcp_pkg::cordic_t      dn_data
);
  import bcp_pkg::*;

  localparam word_t ARC = arc_at(STEP);

  word_t   dx;
  word_t   dy;
  cordic_t data_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    dx             = up_data.y >>> STEP;
    dy             = up_data.x >>> STEP;
    data_next.quad = up_data.quad;
    if (up_data.z >= 0) begin
      data_next.x = up_data.x - dx;
      data_next.y = up_data.y + dy;
      data_next.z = up_data.z - ARC;
    end else begin
      data_next.x = up_data.x + dx;
      data_next.y = up_data.y - dy;
      data_next.z = up_data.z + ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/bcp_post.sv -----
// quadrant fold, cubes, radius, products, rounding and saturation stages
`default_nettype none
module bcp_post #(
  parameter int SAMPLE_BITS = bcp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire bcp_pkg::cordic_t         in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [SAMPLE_BITS-1:0] x_pos,
  output logic signed [SAMPLE_BITS-1:0] y_pos
);
  import bcp_pkg::*;

  localparam int NSTAGE = 6;
  localparam int SHIFT  = 31 - SAMPLE_BITS;
  localparam logic signed [35:0] HALF = 36'sd1 <<< (SHIFT - 1);
  localparam logic signed [35:0] TOP  = (36'sd1 <<< (SAMPLE_BITS - 1)) - 36'sd1;
  localparam logic signed [35:0] BOT  = -(36'sd1 <<< (SAMPLE_BITS - 1));

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] adv;

  // stage registers
  word_t s1, c1;
  word_t s2, c2, s2s, c2c;
  word_t s3, c3, s3s, c3c;
  logic signed [32:0] r4;
  word_t s4, c4;
  logic signed [34:0] ps5, pc5;

  word_t s1_next, c1_next;
  logic signed [63:0] sq_s, sq_c, cu_s, cu_c;
  logic signed [64:0] m_s, m_c;
  logic signed [35:0] rnd_s, rnd_c, sat_s, sat_c;

  always_comb begin
    adv[NSTAGE-1] = !v[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NSTAGE-1];

  always_comb begin
    case (in_data.quad)
      QUAD_I: begin
        s1_next = in_data.y;
        c1_next = in_data.x;
      end
      QUAD_II: begin
        s1_next = in_data.x;
        c1_next = -in_data.y;
      end
      QUAD_III: begin
        s1_next = -in_data.y;
        c1_next = -in_data.x;
      end
      default: begin
        s1_next = -in_data.x;
        c1_next = in_data.y;
      end
    endcase
  end

  always_comb begin
    sq_s  = s1 * s1;
    sq_c  = c1 * c1;
    cu_s  = s2 * s2s;
    cu_c  = c2 * c2c;
    m_s   = s4 * r4;
    m_c   = c4 * r4;
    rnd_s = (36'(ps5) + HALF) >>> SHIFT;
    rnd_c = (36'(pc5) + HALF) >>> SHIFT;
    sat_s = (rnd_s > TOP) ? TOP : ((rnd_s < BOT) ? BOT : rnd_s);
    sat_c = (rnd_c > TOP) ? TOP : ((rnd_c < BOT) ? BOT : rnd_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (adv[k]) begin
          v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1 <= s1_next;
      c1 <= c1_next;
    end
    if (adv[1]) begin
      s2  <= WORD_BITS'(sq_s >>> FRAC_BITS);
      c2  <= WORD_BITS'(sq_c >>> FRAC_BITS);
      s2s <= s1;
      c2c <= c1;
    end
    if (adv[2]) begin
      s3  <= WORD_BITS'(cu_s >>> FRAC_BITS);
      c3  <= WORD_BITS'(cu_c >>> FRAC_BITS);
      s3s <= s2s;
      c3c <= c2c;
    end
    if (adv[3]) begin
      r4 <= 33'(s3) + 33'(c3);
      s4 <= s3s;
      c4 <= c3c;
    end
    if (adv[4]) begin
      ps5 <= 35'(m_s >>> FRAC_BITS);
      pc5 <= 35'(m_c >>> FRAC_BITS);
    end
    if (adv[5]) begin
      x_pos <= SAMPLE_BITS'(sat_s);
      y_pos <= SAMPLE_BITS'(sat_c);
    end
  end

endmodule
`default_nettype wire

// ----- sv/bean_curve_point.sv -----
// top level of the bean curve point generator
// usage:
//   input channel: in_valid / in_ready with turn_phase, an unsigned fraction of
//   a full turn (2^PHASE_BITS is one turn). output channel: out_valid /
//   out_ready with x_pos = sin(t)*r and y_pos = cos(t)*r, signed
//   Q1.(SAMPLE_BITS-1), rounded and saturated, r = sin(t)^3 + cos(t)^3.
//   one result item for every input item, in order.
//   path: an accepted item passes the chain of 28 cordic cells, then 6 post
//   stages: quadrant fold, squares, cubes, radius, products, round/saturate.
//   throughput: one item per cycle if out_ready is high; one rotation per cell.
//   each stage has its own valid bit and moves when the stage after it is
//   empty or moving, so empty slots close up while the receiver stalls and
//   in_ready drops only once every stage holds an item.
//   reset: synchronous, clears every valid bit; no item is held afterwards.
`default_nettype none
module bean_curve_point #(
  parameter int PHASE_BITS  = bcp_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = bcp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [PHASE_BITS-1:0]    turn_phase,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [SAMPLE_BITS-1:0] x_pos,
  output logic signed [SAMPLE_BITS-1:0] y_pos
);
  import bcp_pkg::*;

  logic                    st_valid [CORDIC_STEPS+1];
  logic                    st_ready [CORDIC_STEPS+1];
  cordic_t                 st_data  [CORDIC_STEPS+1];
  logic [ANGLE_BITS-1:0]   angle;

  assign angle = {turn_phase, {(ANGLE_BITS - PHASE_BITS){1'b0}}};

  assign st_valid[0]     = in_valid;
  assign in_ready        = st_ready[0];
  assign st_data[0].x    = CORDIC_GAIN;
  assign st_data[0].y    = '0;
  assign st_data[0].z    = {2'b00, angle[FRAC_BITS-1:0]};
  assign st_data[0].quad = angle[ANGLE_BITS-1 -: 2];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    bcp_cordic_cell #(
      .STEP (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (st_valid[k]),
      .up_ready (st_ready[k]),
      .up_data  (st_data[k]),
      .dn_valid (st_valid[k+1]),
      .dn_ready (st_ready[k+1]),
      .dn_data  (st_data[k+1])
    );
  end

  bcp_post #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[CORDIC_STEPS]),
    .in_ready  (st_ready[CORDIC_STEPS]),
    .in_data   (st_data[CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_pos     (x_pos),
    .y_pos     (y_pos)
  );

`ifndef ASSERT_OFF
  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output is not stalled");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present right after reset");

  a_first_cell_holds: assert property (@(posedge clk) disable iff (rst)
    (st_valid[1] && !st_ready[1]) |=> (st_valid[1] && $stable(st_data[1])))
    else $error("first cordic cell lost or changed a stalled item");
`endif

endmodule
`default_nettype wire
